>>> design/mtg_pkg.sv
// Shared types, constants and word functions of the MT19937 generator.
package mtg_pkg;

    localparam int STORE_LEN = 624;
    localparam int FAR_OFF   = 397;
    localparam int ADDR_W    = $clog2(STORE_LEN);
    localparam int WORD_W    = 32;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_addr LAST_ADDR  = t_addr'(STORE_LEN - 1);
    localparam t_addr FAR_WRAP   = t_addr'(STORE_LEN - FAR_OFF);
    localparam t_addr FAR_STEP   = t_addr'(FAR_OFF);

    localparam t_word SEED_RESET = 32'd5489;
    localparam t_word INIT_MUL   = 32'd1812433253;
    localparam t_word TWIST_MAT  = 32'h9908b0df;
    localparam t_word UPPER_MASK = 32'h80000000;
    localparam t_word LOWER_MASK = 32'h7fffffff;
    localparam t_word TEMPER_B   = 32'h9d2c5680;
    localparam t_word TEMPER_C   = 32'hefc60000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL_MUL,
        ST_FILL_ADD,
        ST_READ,
        ST_MIX
    } t_state;

    function automatic t_word mix_word(input t_word upper_src, input t_word lower_src,
                                       input t_word far);
        t_word h;
        t_word r;
        h = (upper_src & UPPER_MASK) | (lower_src & LOWER_MASK);
        r = far ^ (h >> 1);
        if (h[0]) begin
            r = r ^ TWIST_MAT;
        end
        return r;
    endfunction

    function automatic t_word temper(input t_word e);
        t_word y;
        y = e ^ (e >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> design/mtg_ifs.sv
// Valid/ready channels of the generator: the request channel and the word channel.
interface mtg_req_if;
    logic valid;
    logic ready;
    logic request;

    modport source (output valid, output request, input ready);
    modport sink   (input valid, input request, output ready);
endinterface

interface mtg_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

>>> design/mersenne_twister_generator.sv
// MT19937 generator: one tempered 32-bit word per request, twisting one state word per output.
// The 624-word state lives in one memory with two registered read ports and one write port.
// Once the store is filled, a request with the request bit set is accepted in ST_IDLE, which
// issues the reads of the following word and of the word 397 places on; ST_MIX then mixes,
// writes the twisted word back and loads the output register, waiting while the output
// register holds a word that is not taken. A beat with the request bit clear is accepted
// and yields nothing. The first request after reset first fills the store from the seed
// register, a multiply step and an add step per later word; the seed is read only then.
// While a finished word waits at the output, the next request is still accepted.
module mersenne_twister_generator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    mtg_req_if.sink       i_req,
    mtg_word_if.source    o_word
);
    import mtg_pkg::*;

    t_word  mem [STORE_LEN];

    t_state r_state;
    t_state n_state;
    t_word  r_seed;
    logic   r_init;
    t_addr  r_pos;
    t_addr  r_idx;
    t_word  r_prev;
    t_word  r_prod;
    t_word  r_cur;
    t_word  r_rd_next;
    t_word  r_rd_far;

    t_addr  w_addr_next;
    t_addr  w_addr_far;
    logic   w_accept;
    logic   w_rd_en;
    logic   w_wr_en;
    t_addr  w_wr_addr;
    t_word  w_wr_data;
    t_word  w_mixed;
    logic   w_load;
    logic   w_out_free;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_addr_next = (r_pos == LAST_ADDR) ? '0 : r_pos + t_addr'(1);
    assign w_addr_far  = (r_pos < FAR_WRAP) ? r_pos + FAR_STEP : r_pos - FAR_WRAP;
    assign w_mixed     = mix_word(r_cur, r_rd_next, r_rd_far);

    // Seed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_wr_en) begin
            r_seed <= i_cfg_wr_data;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_req.request) begin
                    n_state = r_init ? ST_MIX : ST_FILL_MUL;
                end
            end
            ST_FILL_MUL: n_state = ST_FILL_ADD;
            ST_FILL_ADD: n_state = (r_idx == LAST_ADDR) ? ST_READ : ST_FILL_MUL;
            ST_READ:     n_state = ST_MIX;
            ST_MIX: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control outputs, the read enable and the memory write port.
    always_comb begin
        i_req.ready = 1'b0;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_pos;
        w_wr_data   = w_mixed;
        w_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                w_rd_en     = 1'b1;
                if (w_accept && i_req.request && !r_init) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = '0;
                    w_wr_data = r_seed;
                end
            end
            ST_FILL_MUL: begin
            end
            ST_FILL_ADD: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = r_prod + t_word'(r_idx);
            end
            ST_READ: begin
                w_rd_en = 1'b1;
            end
            ST_MIX: begin
                w_load  = w_out_free;
                w_wr_en = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_init  <= 1'b0;
            r_pos   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && w_accept && i_req.request && !r_init) begin
                r_pos <= '0;
                r_idx <= t_addr'(1);
            end
            if (r_state == ST_FILL_ADD) begin
                r_idx <= r_idx + t_addr'(1);
                if (r_idx == LAST_ADDR) begin
                    r_init <= 1'b1;
                end
            end
            if (w_load) begin
                r_pos <= w_addr_next;
            end
        end
    end

    // Fill datapath and the cached copy of the word at the read position.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept && i_req.request && !r_init) begin
            r_prev <= r_seed;
            r_cur  <= r_seed;
        end
        if (r_state == ST_FILL_MUL) begin
            r_prod <= t_word'(INIT_MUL * (r_prev ^ (r_prev >> 30)));
        end
        if (r_state == ST_FILL_ADD) begin
            r_prev <= w_wr_data;
        end
        // The following word has not been written since it was read, so it is the next base.
        if (w_load) begin
            r_cur <= r_rd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_next <= mem[w_addr_next];
            r_rd_far  <= mem[w_addr_far];
        end
    end

    mtg_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_word  (w_mixed),
        .o_free  (w_out_free),
        .o_word  (o_word)
    );

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_ADDR)
        else $error("read position beyond the store");

    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_state == ST_IDLE)
        else $error("output load did not end the item");

    a_fill_ends_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL_ADD && r_idx == LAST_ADDR) |=> (r_state == ST_READ && r_init))
        else $error("fill pass did not end in a read");

    a_init_goes_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.request && r_init) |=> r_state == ST_MIX)
        else $error("accepted request did not reach the mix cycle");

endmodule

>>> design/mtg_out.sv
// Output stage: tempers a freshly twisted state word and holds it until the beat is taken.
module mtg_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  mtg_pkg::t_word i_word,
    output logic          o_free,
    mtg_word_if.source    o_word
);
    import mtg_pkg::*;

    logic  r_valid;
    t_word r_word;

    assign o_free = !r_valid || o_word.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_word.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= temper(i_word);
        end
    end

    assign o_word.valid       = r_valid;
    assign o_word.random_word = r_word;

endmodule

>>> bench/tb_mersenne_twister_generator.sv
// Self-checking bench for the MT19937 generator: directed rows, then bursty random requests.
module tb_mersenne_twister_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STATE_WORDS   = 624;
    localparam int          FAR_SHIFT     = 397;
    localparam int          UNSEEDED      = 625;
    localparam logic [31:0] SEED_MUL      = 32'd1812433253;
    localparam logic [31:0] TWIST_XOR     = 32'h9908b0df;
    localparam logic [31:0] HIGH_BIT      = 32'h80000000;
    localparam logic [31:0] LOW_BITS      = 32'h7fffffff;
    localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_MASK_C = 32'hefc60000;
    localparam logic [31:0] SEED_DEFAULT  = 32'd5489;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          PRINT_LIMIT   = 20;
    localparam int          WORDS_PER_RUN = 350;
    localparam int          HOLD_AT_WORD  = 200;
    localparam int          HOLD_CYCLES   = 300;

    typedef struct packed {
        logic        req;
        logic        known;
        logic [31:0] word;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    mtg_req_if  req_ch ();
    mtg_word_if word_ch ();

    mersenne_twister_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .o_word        (word_ch)
    );

    // Predictor state: a private copy of the word store, read slot and seed register.
    logic [31:0] state_words [STATE_WORDS];
    int          read_slot = UNSEEDED;
    logic [31:0] seed_reg  = SEED_DEFAULT;

    logic [31:0] expected_words [$];
    int          mismatches    = 0;
    int          words_taken   = 0;
    int          requests_sent = 0;
    int          idle_beats    = 0;
    int          twists        = 0;
    int          seeds_written = 0;

    // The first five words for the default seed are the well-known MT19937 sequence.
    t_row directed_rows [20] = '{
        '{1'b0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 32'd3499211612},
        '{1'b1, 1'b1, 32'd581869302},
        '{1'b0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 32'd3890346734},
        '{1'b1, 1'b1, 32'd3586334585},
        '{1'b1, 1'b1, 32'd545404204},
        '{1'b0, 1'b0, 32'd0},
        '{1'b0, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0},
        '{1'b0, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0},
        '{1'b1, 1'b0, 32'd0}
    };

    function automatic logic [31:0] predict_word();
        logic [31:0] y;
        logic [31:0] h;
        int          i;
        int          nx;
        int          fr;
        if (read_slot > STATE_WORDS) begin
            state_words[0] = seed_reg;
            for (i = 1; i < STATE_WORDS; i++) begin
                state_words[i] = SEED_MUL * (state_words[i-1] ^ (state_words[i-1] >> 30))
                                 + 32'(i);
            end
        end
        // The store is twisted in place, so late entries see already twisted neighbours.
        if (read_slot >= STATE_WORDS) begin
            for (i = 0; i < STATE_WORDS; i++) begin
                nx = (i + 1) % STATE_WORDS;
                fr = (i + FAR_SHIFT) % STATE_WORDS;
                h  = (state_words[i] & HIGH_BIT) | (state_words[nx] & LOW_BITS);
                state_words[i] = state_words[fr] ^ (h >> 1) ^ (h[0] ? TWIST_XOR : 32'd0);
            end
            read_slot = 0;
            twists++;
        end
        y = state_words[read_slot];
        read_slot++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_MASK_B);
        y = y ^ ((y << 15) & TEMPER_MASK_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT) begin
            $display("ERROR %0t ns: %s: got %08h, expected %08h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid still high so that a following beat can go straight out.
    task automatic offer(input logic req, input logic known, input logic [31:0] typed_word);
        logic [31:0] w;
        req_ch.valid   <= 1'b1;
        req_ch.request <= req;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        if (req) begin
            w = predict_word();
            expected_words.push_back(known ? typed_word : w);
            requests_sent++;
        end else begin
            idle_beats++;
        end
        @(negedge i_clk);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        seed_reg = value;
        seeds_written++;
    endtask

    task automatic random_requests(input int wanted);
        int   sent;
        int   burst;
        int   k;
        logic req;
        sent = 0;
        while (sent < wanted) begin
            burst = $urandom_range(1, 32);
            for (k = 0; k < burst && sent < wanted; k++) begin
                req = ($urandom_range(0, 7) != 0);
                offer(req, 1'b0, 32'd0);
                if (req) begin
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && word_ch.valid === 1'b1 && word_ch.ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing outstanding", word_ch.random_word, 32'd0);
            end else if (word_ch.random_word !== expected_words[0]) begin
                report_mismatch("random_word", word_ch.random_word, expected_words[0]);
                void'(expected_words.pop_front());
            end else begin
                void'(expected_words.pop_front());
            end
            words_taken++;
        end
    end

    // Receiver: segments of full rate, random stalls and short dead runs, plus one long
    // hold-off that lets the block back up and stall the request side.
    initial begin : word_sink
        int  seg_mode;
        int  seg_len;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        word_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!long_hold_done && words_taken >= HOLD_AT_WORD) begin
                long_hold_done = 1'b1;
                word_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            seg_mode = $urandom_range(0, 3);
            seg_len  = (seg_mode == 3) ? $urandom_range(1, 8) : $urandom_range(4, 40);
            repeat (seg_len) begin
                case (seg_mode)
                    0: begin
                        word_ch.ready <= 1'b1;
                    end
                    1: begin
                        word_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        word_ch.ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        word_ch.ready <= 1'b0;
                    end
                endcase
                @(negedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d words outstanding.",
                 cycles, expected_words.size());
        $display("FAIL mersenne_twister_generator");
        $finish;
    end

    initial begin : stimulus
        int r;
        i_rst_n        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 32'd0;
        req_ch.valid   = 1'b0;
        req_ch.request = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows run on the seed left by reset; the first request also fills the store.
        for (r = 0; r < $size(directed_rows); r++) begin
            offer(directed_rows[r].req, directed_rows[r].known, directed_rows[r].word);
            if (r % 6 == 5) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end
        end
        settle();

        // Seed writes after the first fill must leave the sequence untouched.
        write_seed(32'h00000000);
        random_requests(WORDS_PER_RUN);
        settle();
        write_seed(32'hffffffff);
        random_requests(WORDS_PER_RUN);
        settle();
        write_seed($urandom);
        random_requests(WORDS_PER_RUN);
        settle();

        $display("Covered %0d requests and %0d empty beats, %0d words checked, %0d twists.",
                 requests_sent, idle_beats, words_taken, twists);
        $display("Seed register written %0d times after the first fill; %0d mismatches.",
                 seeds_written, mismatches);
        if (mismatches == 0) begin
            $display("PASS mersenne_twister_generator");
        end else begin
            $display("FAIL mersenne_twister_generator");
        end
        $finish;
    end

endmodule
